// File: design/tkhq_pkg.sv
// shared types, constants and codes for the two-key max heap queue
package tkhq_pkg;

   localparam int DEPTH      = 256;
   localparam int PRIO_WIDTH = 32;
   localparam int TAG_WIDTH  = 32;
   localparam int IDX_W      = $clog2(DEPTH);
   localparam int CNT_W      = 9;

   typedef struct packed {
      logic [PRIO_WIDTH-1:0] major;
      logic [PRIO_WIDTH-1:0] minor;
      logic [TAG_WIDTH-1:0]  tag;
   } entry_type;

   typedef enum logic [1:0] {
      STATUS_DONE  = 2'd0,
      STATUS_FULL  = 2'd1,
      STATUS_EMPTY = 2'd2
   } status_type;

   typedef enum logic {
      REQ_INSERT = 1'b0,
      REQ_REMOVE = 1'b1
   } req_kind_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_RM_ROOT,
      ST_RM_TAIL,
      ST_RM_LOAD,
      ST_UP_READ,
      ST_UP_CMP,
      ST_DN_READ_L,
      ST_DN_READ_R,
      ST_DN_PICK,
      ST_DN_CMP
   } state_type;

endpackage

// File: design/two_key_max_heap_queue_core.sv
// two-key max-priority queue top level: sequencer, heap memory and result registers
//
// Each request is taken when start is high and busy is low, and answers with one result
// that stands on the rsp_ ports for a single cycle while rsp_valid is high; the receiver
// cannot stall it. A refused insert (queue full) or a remove on an empty queue answers in
// the cycle after the transfer. An insert that succeeds climbs the heap level by level,
// reading the parent in ST_UP_READ and comparing and writing in ST_UP_CMP. A remove
// fetches root and tail in ST_RM_ROOT, ST_RM_TAIL and ST_RM_LOAD, then on each level down
// reads the left and right child, picks the larger and compares it with the moving entry;
// the root has a single child and skips the pick. The sequencer uses the one heap memory
// read port, read once or twice per level, and the single comparator shared by all steps.
// A new request may be started in the cycle its predecessor's result appears.
// Heap storage needs no clearing after reset.
module two_key_max_heap_queue_core
   import tkhq_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   output logic                  busy,
   input  logic                  req_type,
   input  logic [PRIO_WIDTH-1:0] req_prio_major,
   input  logic [PRIO_WIDTH-1:0] req_prio_minor,
   input  logic [TAG_WIDTH-1:0]  req_payload_tag,
   output logic                  rsp_valid,
   output logic [1:0]            rsp_status,
   output logic [PRIO_WIDTH-1:0] rsp_out_major,
   output logic [PRIO_WIDTH-1:0] rsp_out_minor,
   output logic [TAG_WIDTH-1:0]  rsp_out_tag,
   output logic [CNT_W-1:0]      rsp_entry_count,
   input  logic                  csr_valid,
   output logic                  csr_ready,
   input  logic [CNT_W-1:0]      csr_wdata
);

   state_type        state_ff, state_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic [CNT_W-1:0] cap_ff, cap_in;
   entry_type        cur_ff, cur_in;
   entry_type        best_ff, best_in;
   entry_type        left_ff, left_in;
   entry_type        res_ff, res_in;
   logic [IDX_W-1:0] k_ff, k_in;
   logic [IDX_W-1:0] best_idx_ff, best_idx_in;
   logic             rsp_valid_ff, rsp_valid_in;
   status_type       rsp_status_ff, rsp_status_in;
   logic [CNT_W-1:0] rsp_count_ff, rsp_count_in;

   entry_type        mem [DEPTH];
   entry_type        rdata_ff;
   logic             mem_we;
   logic [IDX_W-1:0] mem_waddr;
   logic [IDX_W-1:0] mem_raddr;
   entry_type        mem_wdata;

   entry_type        cmp_lhs, cmp_rhs;
   logic             cmp_below;

   logic [CNT_W-1:0] cap_eff;
   logic [CNT_W-1:0] k_wide;
   logic [CNT_W-1:0] left_idx;
   logic [CNT_W-1:0] right_idx;
   logic             has_left;
   logic             has_right;
   logic             accept;
   entry_type        req_entry;

   tkhq_rank_cmp u_cmp (
      .lhs   (cmp_lhs),
      .rhs   (cmp_rhs),
      .below (cmp_below)
   );

   assign accept    = start && !busy;
   assign req_entry = '{major: req_prio_major, minor: req_prio_minor, tag: req_payload_tag};
   assign cap_eff   = (cap_ff > CNT_W'(DEPTH)) ? CNT_W'(DEPTH) : cap_ff;
   assign k_wide    = CNT_W'(k_ff);
   assign left_idx  = (k_ff == '0) ? CNT_W'(1) : CNT_W'({k_ff, 1'b0});
   assign right_idx = left_idx + CNT_W'(1);
   assign has_left  = (left_idx < count_ff);
   assign has_right = (k_ff != '0) && (right_idx < count_ff);

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               if (req_type == REQ_INSERT) begin
                  if (count_ff < cap_eff) begin
                     state_in = ST_UP_READ;
                  end
               end else if (count_ff != '0) begin
                  state_in = ST_RM_ROOT;
               end
            end
         end
         ST_RM_ROOT: state_in = ST_RM_TAIL;
         ST_RM_TAIL: state_in = ST_RM_LOAD;
         ST_RM_LOAD: state_in = ST_DN_READ_L;
         ST_UP_READ: begin
            state_in = (k_ff == '0) ? ST_IDLE : ST_UP_CMP;
         end
         ST_UP_CMP: begin
            state_in = cmp_below ? ST_UP_READ : ST_IDLE;
         end
         ST_DN_READ_L: begin
            state_in = has_left ? ST_DN_READ_R : ST_IDLE;
         end
         ST_DN_READ_R: begin
            state_in = has_right ? ST_DN_PICK : ST_DN_CMP;
         end
         ST_DN_PICK: state_in = ST_DN_CMP;
         ST_DN_CMP: begin
            state_in = cmp_below ? ST_DN_READ_L : ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // datapath and memory control
   always_comb begin
      count_in      = count_ff;
      cur_in        = cur_ff;
      best_in       = best_ff;
      best_idx_in   = best_idx_ff;
      left_in       = left_ff;
      res_in        = res_ff;
      k_in          = k_ff;
      rsp_valid_in  = 1'b0;
      rsp_status_in = rsp_status_ff;
      rsp_count_in  = rsp_count_ff;
      mem_we        = 1'b0;
      mem_waddr     = k_ff;
      mem_wdata     = cur_ff;
      mem_raddr     = k_ff;
      cmp_lhs       = rdata_ff;
      cmp_rhs       = cur_ff;
      cap_in        = (csr_valid && csr_ready) ? csr_wdata : cap_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               if (req_type == REQ_INSERT) begin
                  res_in = '0;
                  if (count_ff < cap_eff) begin
                     cur_in   = req_entry;
                     k_in     = count_ff[IDX_W-1:0];
                     count_in = count_ff + CNT_W'(1);
                  end else begin
                     rsp_valid_in  = 1'b1;
                     rsp_status_in = STATUS_FULL;
                     rsp_count_in  = count_ff;
                  end
               end else if (count_ff != '0) begin
                  count_in = count_ff - CNT_W'(1);
               end else begin
                  res_in        = '0;
                  rsp_valid_in  = 1'b1;
                  rsp_status_in = STATUS_EMPTY;
                  rsp_count_in  = count_ff;
               end
            end
         end
         ST_RM_ROOT: begin
            mem_raddr = '0;
         end
         ST_RM_TAIL: begin
            mem_raddr = count_ff[IDX_W-1:0];
            res_in    = rdata_ff;
         end
         ST_RM_LOAD: begin
            cur_in = rdata_ff;
            k_in   = '0;
         end
         ST_UP_READ: begin
            if (k_ff == '0) begin
               mem_we        = 1'b1;
               rsp_valid_in  = 1'b1;
               rsp_status_in = STATUS_DONE;
               rsp_count_in  = count_ff;
            end else begin
               mem_raddr = k_ff >> 1;
            end
         end
         ST_UP_CMP: begin
            mem_we = 1'b1;
            if (cmp_below) begin
               mem_wdata = rdata_ff;
               k_in      = k_ff >> 1;
            end else begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = STATUS_DONE;
               rsp_count_in  = count_ff;
            end
         end
         ST_DN_READ_L: begin
            if (has_left) begin
               mem_raddr = left_idx[IDX_W-1:0];
            end else begin
               mem_we        = (k_wide < count_ff);
               rsp_valid_in  = 1'b1;
               rsp_status_in = STATUS_DONE;
               rsp_count_in  = count_ff;
            end
         end
         ST_DN_READ_R: begin
            left_in = rdata_ff;
            if (has_right) begin
               mem_raddr = right_idx[IDX_W-1:0];
            end else begin
               best_in     = rdata_ff;
               best_idx_in = left_idx[IDX_W-1:0];
            end
         end
         ST_DN_PICK: begin
            cmp_lhs = left_ff;
            cmp_rhs = rdata_ff;
            if (cmp_below) begin
               best_in     = rdata_ff;
               best_idx_in = right_idx[IDX_W-1:0];
            end else begin
               best_in     = left_ff;
               best_idx_in = left_idx[IDX_W-1:0];
            end
         end
         ST_DN_CMP: begin
            cmp_lhs = cur_ff;
            cmp_rhs = best_ff;
            mem_we  = 1'b1;
            if (cmp_below) begin
               mem_wdata = best_ff;
               k_in      = best_idx_ff;
            end else begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = STATUS_DONE;
               rsp_count_in  = count_ff;
            end
         end
         default: begin
            mem_we = 1'b0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         cap_ff       <= CNT_W'(256);
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         cap_ff       <= cap_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      cur_ff        <= cur_in;
      best_ff       <= best_in;
      best_idx_ff   <= best_idx_in;
      left_ff       <= left_in;
      res_ff        <= res_in;
      k_ff          <= k_in;
      rsp_status_ff <= rsp_status_in;
      rsp_count_ff  <= rsp_count_in;
   end

   // heap storage
   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[mem_waddr] <= mem_wdata;
      end
      rdata_ff <= mem[mem_raddr];
   end

   assign busy            = (state_ff != ST_IDLE);
   assign csr_ready       = 1'b1;
   assign rsp_valid       = rsp_valid_ff;
   assign rsp_status      = rsp_status_ff;
   assign rsp_out_major   = res_ff.major;
   assign rsp_out_minor   = res_ff.minor;
   assign rsp_out_tag     = res_ff.tag;
   assign rsp_entry_count = rsp_count_ff;

`ifndef SYNTHESIS
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(DEPTH))
      else $error("held count above depth");

   a_write_in_heap: assert property (@(posedge clock) disable iff (reset)
      mem_we |-> (CNT_W'(mem_waddr) < count_ff))
      else $error("heap write outside held entries");

   a_rsp_when_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !busy)
      else $error("result strobe while sequencer busy");

   a_busy_from_start: assert property (@(posedge clock) disable iff (reset)
      $rose(busy) |-> $past(start))
      else $error("sequencer left idle without a request transfer");

   a_empty_result: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_status == STATUS_EMPTY) |->
         (rsp_entry_count == '0 && rsp_out_tag == '0 && rsp_out_major == '0))
      else $error("empty result carries data");
`endif

endmodule

// File: design/tkhq_rank_cmp.sv
// shared lexicographic rank comparator: lhs ranks strictly below rhs
module tkhq_rank_cmp
   import tkhq_pkg::*;
(
   input  entry_type lhs,
   input  entry_type rhs,
   output logic      below
);

   always_comb begin
      if (lhs.major != rhs.major) begin
         below = (lhs.major < rhs.major);
      end else begin
         below = (lhs.minor < rhs.minor);
      end
   end

endmodule

// File: verif/two_key_max_heap_queue_core_tb.sv
// testbench for the two-key max heap queue: scripted and random requests checked against a heap model
`timescale 1ns / 1ps

module two_key_max_heap_queue_core_tb
   import tkhq_pkg::*;
;

   typedef struct packed {
      status_type            status;
      logic [PRIO_WIDTH-1:0] major;
      logic [PRIO_WIDTH-1:0] minor;
      logic [TAG_WIDTH-1:0]  tag;
      logic [CNT_W-1:0]      count;
   } heap_answer_t;

   typedef struct packed {
      logic         fixed;
      heap_answer_t ans;
   } typed_answer_t;

   typedef enum logic [1:0] {
      ROW_INSERT,
      ROW_REMOVE,
      ROW_CSR
   } row_kind_t;

   typedef struct packed {
      row_kind_t             kind;
      logic [PRIO_WIDTH-1:0] major;
      logic [PRIO_WIDTH-1:0] minor;
      logic [TAG_WIDTH-1:0]  tag;
      logic [CNT_W-1:0]      value;
      logic                  fixed;
      status_type            st;
      logic [CNT_W-1:0]      cnt;
   } script_row_t;

   localparam int SCRIPT_LEN = 26;
   localparam int PHASES     = 8;
   localparam int END_CYCLES = 4 * IDX_W + 12;

   logic                  clock;
   logic                  reset;
   logic                  start;
   logic                  busy;
   logic                  req_type;
   logic [PRIO_WIDTH-1:0] req_prio_major;
   logic [PRIO_WIDTH-1:0] req_prio_minor;
   logic [TAG_WIDTH-1:0]  req_payload_tag;
   logic                  rsp_valid;
   logic [1:0]            rsp_status;
   logic [PRIO_WIDTH-1:0] rsp_out_major;
   logic [PRIO_WIDTH-1:0] rsp_out_minor;
   logic [TAG_WIDTH-1:0]  rsp_out_tag;
   logic [CNT_W-1:0]      rsp_entry_count;
   logic                  csr_valid;
   logic                  csr_ready;
   logic [CNT_W-1:0]      csr_wdata;

   two_key_max_heap_queue_core dut (
      .clock           (clock),
      .reset           (reset),
      .start           (start),
      .busy            (busy),
      .req_type        (req_type),
      .req_prio_major  (req_prio_major),
      .req_prio_minor  (req_prio_minor),
      .req_payload_tag (req_payload_tag),
      .rsp_valid       (rsp_valid),
      .rsp_status      (rsp_status),
      .rsp_out_major   (rsp_out_major),
      .rsp_out_minor   (rsp_out_minor),
      .rsp_out_tag     (rsp_out_tag),
      .rsp_entry_count (rsp_entry_count),
      .csr_valid       (csr_valid),
      .csr_ready       (csr_ready),
      .csr_wdata       (csr_wdata)
   );

   entry_type        heap_mem [DEPTH];
   int unsigned      heap_fill = 0;
   logic [CNT_W-1:0] capacity_reg = 9'd256;

   heap_answer_t  heap_answers [$];
   typed_answer_t typed_answers [$];

   int mismatches     = 0;
   int answers_seen   = 0;
   int requests_taken = 0;
   int stored_count   = 0;
   int removed_count  = 0;
   int full_count     = 0;
   int empty_count    = 0;
   int peak_fill      = 0;
   int csr_writes     = 0;

   script_row_t script [SCRIPT_LEN] = '{
      '{ROW_REMOVE, 32'h0, 32'h0, 32'h0, 9'd0, 1'b1, STATUS_EMPTY, 9'd0},
      '{ROW_INSERT, 32'hFFFFFFFF, 32'hFFFFFFFF, 32'hFFFFFFFF, 9'd0, 1'b1, STATUS_DONE, 9'd1},
      '{ROW_INSERT, 32'h0, 32'h0, 32'h0, 9'd0, 1'b1, STATUS_DONE, 9'd2},
      '{ROW_INSERT, 32'hFFFFFFFF, 32'hFFFFFFFF, 32'h1, 9'd0, 1'b1, STATUS_DONE, 9'd3},
      '{ROW_INSERT, 32'hFFFFFFFF, 32'h0, 32'hAAAAAAAA, 9'd0, 1'b0, STATUS_DONE, 9'd0},
      '{ROW_INSERT, 32'h0, 32'hFFFFFFFF, 32'h55555555, 9'd0, 1'b0, STATUS_DONE, 9'd0},
      '{ROW_INSERT, 32'h80000000, 32'h1, 32'h12345678, 9'd0, 1'b0, STATUS_DONE, 9'd0},
      '{ROW_REMOVE, 32'h0, 32'h0, 32'h0, 9'd0, 1'b0, STATUS_DONE, 9'd0},
      '{ROW_REMOVE, 32'h0, 32'h0, 32'h0, 9'd0, 1'b0, STATUS_DONE, 9'd0},
      '{ROW_REMOVE, 32'h0, 32'h0, 32'h0, 9'd0, 1'b0, STATUS_DONE, 9'd0},
      '{ROW_CSR, 32'h0, 32'h0, 32'h0, 9'd2, 1'b0, STATUS_DONE, 9'd0},
      '{ROW_INSERT, 32'h7, 32'h7, 32'h7, 9'd0, 1'b1, STATUS_FULL, 9'd3},
      '{ROW_REMOVE, 32'h0, 32'h0, 32'h0, 9'd0, 1'b0, STATUS_DONE, 9'd0},
      '{ROW_REMOVE, 32'h0, 32'h0, 32'h0, 9'd0, 1'b0, STATUS_DONE, 9'd0},
      '{ROW_INSERT, 32'h9, 32'h9, 32'h9, 9'd0, 1'b1, STATUS_DONE, 9'd2},
      '{ROW_CSR, 32'h0, 32'h0, 32'h0, 9'd0, 1'b0, STATUS_DONE, 9'd0},
      '{ROW_INSERT, 32'hFFFFFFFF, 32'hFFFFFFFF, 32'hFFFFFFFF, 9'd0, 1'b1, STATUS_FULL, 9'd2},
      '{ROW_REMOVE, 32'h0, 32'h0, 32'h0, 9'd0, 1'b0, STATUS_DONE, 9'd0},
      '{ROW_REMOVE, 32'h0, 32'h0, 32'h0, 9'd0, 1'b0, STATUS_DONE, 9'd0},
      '{ROW_REMOVE, 32'h0, 32'h0, 32'h0, 9'd0, 1'b1, STATUS_EMPTY, 9'd0},
      '{ROW_CSR, 32'h0, 32'h0, 32'h0, 9'd511, 1'b0, STATUS_DONE, 9'd0},
      '{ROW_INSERT, 32'hFFFFFFFF, 32'hFFFFFFFF, 32'h0, 9'd0, 1'b0, STATUS_DONE, 9'd0},
      '{ROW_INSERT, 32'h1, 32'h2, 32'h3, 9'd0, 1'b0, STATUS_DONE, 9'd0},
      '{ROW_REMOVE, 32'h0, 32'h0, 32'h0, 9'd0, 1'b0, STATUS_DONE, 9'd0},
      '{ROW_CSR, 32'h0, 32'h0, 32'h0, 9'd256, 1'b0, STATUS_DONE, 9'd0},
      '{ROW_REMOVE, 32'h0, 32'h0, 32'h0, 9'd0, 1'b0, STATUS_DONE, 9'd0}
   };

   // -1 picks a random capacity
   int phase_cap     [PHASES] = '{256, 511, 1, 0, 3, 300, 17, -1};
   int phase_items   [PHASES] = '{320, 300, 65, 65, 65, 65, 65, 65};
   int phase_ins_pct [PHASES] = '{95, 8, 60, 50, 55, 70, 55, 50};

   function automatic logic ranks_below(input entry_type a, input entry_type b);
      return {a.major, a.minor} < {b.major, b.minor};
   endfunction

   function automatic void swap_entries(input int unsigned a, input int unsigned b);
      entry_type tmp;
      tmp         = heap_mem[a];
      heap_mem[a] = heap_mem[b];
      heap_mem[b] = tmp;
   endfunction

   function automatic heap_answer_t heap_apply(input req_kind_type kind, input entry_type item);
      heap_answer_t ans;
      int unsigned  k;
      int unsigned  c;
      int unsigned  limit;
      ans        = '0;
      ans.status = STATUS_DONE;
      limit      = (capacity_reg > DEPTH) ? DEPTH : capacity_reg;
      if (kind == REQ_INSERT) begin
         if (heap_fill >= limit) begin
            ans.status = STATUS_FULL;
         end else begin
            k           = heap_fill;
            heap_mem[k] = item;
            heap_fill++;
            while (k > 0 && ranks_below(heap_mem[k / 2], heap_mem[k])) begin
               swap_entries(k, k / 2);
               k = k / 2;
            end
         end
      end else if (heap_fill == 0) begin
         ans.status = STATUS_EMPTY;
      end else begin
         ans.major = heap_mem[0].major;
         ans.minor = heap_mem[0].minor;
         ans.tag   = heap_mem[0].tag;
         heap_fill--;
         heap_mem[0] = heap_mem[heap_fill];
         k = 0;
         while (2 * k < heap_fill) begin
            c = 2 * k;
            if (c + 1 < heap_fill && ranks_below(heap_mem[c], heap_mem[c + 1])) c++;
            if (c == k || !ranks_below(heap_mem[k], heap_mem[c])) break;
            swap_entries(k, c);
            k = c;
         end
      end
      ans.count = heap_fill[CNT_W-1:0];
      return ans;
   endfunction

   task automatic flag_mismatch(input string field, input logic [31:0] got,
                                input logic [31:0] want);
      if (mismatches < 40)
         $display("mismatch on %s at result %0d: got %h, want %h", field, answers_seen, got,
                  want);
      mismatches++;
   endtask

   function automatic logic [31:0] pick_key();
      case ($urandom_range(0, 5))
         0:       return 32'h0;
         1:       return 32'hFFFFFFFF;
         2, 3:    return $urandom_range(0, 3);
         default: return $urandom;
      endcase
   endfunction

   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (r < 60) return 0;
      if (r < 92) return $urandom_range(1, 3);
      return $urandom_range(10, 60);
   endfunction

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   // result check first, then the request transfer of the same edge
   always @(posedge clock) begin
      heap_answer_t  want;
      typed_answer_t typed;
      if (!reset) begin
         if (rsp_valid) begin
            answers_seen++;
            if (heap_answers.size() == 0) begin
               flag_mismatch("unrequested result", {30'd0, rsp_status}, 32'd0);
            end else begin
               want = heap_answers.pop_front();
               if (rsp_status != want.status)
                  flag_mismatch("status", {30'd0, rsp_status}, {30'd0, want.status});
               if (rsp_out_major != want.major) flag_mismatch("major", rsp_out_major, want.major);
               if (rsp_out_minor != want.minor) flag_mismatch("minor", rsp_out_minor, want.minor);
               if (rsp_out_tag != want.tag) flag_mismatch("tag", rsp_out_tag, want.tag);
               if (rsp_entry_count != want.count)
                  flag_mismatch("entry count", {23'd0, rsp_entry_count}, {23'd0, want.count});
            end
         end
         if (csr_valid && csr_ready) begin
            capacity_reg = csr_wdata;
            csr_writes++;
         end
         if (start && !busy) begin
            requests_taken++;
            typed = typed_answers.pop_front();
            want  = heap_apply(req_kind_type'(req_type),
                               '{major: req_prio_major, minor: req_prio_minor,
                                 tag: req_payload_tag});
            case (want.status)
               STATUS_FULL:  full_count++;
               STATUS_EMPTY: empty_count++;
               default:      if (req_type == REQ_INSERT) stored_count++; else removed_count++;
            endcase
            if (heap_fill > peak_fill) peak_fill = heap_fill;
            heap_answers.push_back(typed.fixed ? typed.ans : want);
         end
      end
   end

   task automatic send_request(input req_kind_type kind, input logic [PRIO_WIDTH-1:0] major,
                               input logic [PRIO_WIDTH-1:0] minor,
                               input logic [TAG_WIDTH-1:0] tag, input int gap,
                               input typed_answer_t typed);
      if (gap > 0) begin
         start = 1'b0;
         repeat (gap) @(negedge clock);
      end
      typed_answers.push_back(typed);
      req_type        = kind;
      req_prio_major  = major;
      req_prio_minor  = minor;
      req_payload_tag = tag;
      start           = 1'b1;
      do @(posedge clock); while (busy);
      @(negedge clock);
   endtask

   task automatic write_capacity(input logic [CNT_W-1:0] value);
      start = 1'b0;
      while (heap_answers.size() != 0) @(negedge clock);
      csr_wdata = value;
      csr_valid = 1'b1;
      do @(posedge clock); while (!csr_ready);
      @(negedge clock);
      csr_valid = 1'b0;
   endtask

   initial begin
      typed_answer_t typed;
      req_kind_type  kind;
      int            cap;
      logic          quiet;
      reset           = 1'b1;
      start           = 1'b0;
      req_type        = REQ_INSERT;
      req_prio_major  = '0;
      req_prio_minor  = '0;
      req_payload_tag = '0;
      csr_valid       = 1'b0;
      csr_wdata       = '0;
      repeat (10) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      for (int r = 0; r < SCRIPT_LEN; r++) begin
         if (script[r].kind == ROW_CSR) begin
            write_capacity(script[r].value);
         end else begin
            typed            = '0;
            typed.fixed      = script[r].fixed;
            typed.ans.status = script[r].st;
            typed.ans.count  = script[r].cnt;
            kind = (script[r].kind == ROW_INSERT) ? REQ_INSERT : REQ_REMOVE;
            send_request(kind, script[r].major, script[r].minor, script[r].tag, pick_gap(),
                         typed);
         end
      end

      for (int p = 0; p < PHASES; p++) begin
         cap = (phase_cap[p] < 0) ? $urandom_range(0, 511) : phase_cap[p];
         write_capacity(cap[CNT_W-1:0]);
         quiet = (p == 4);
         for (int i = 0; i < phase_items[p]; i++) begin
            kind = ($urandom_range(0, 99) < phase_ins_pct[p]) ? REQ_INSERT : REQ_REMOVE;
            send_request(kind, pick_key(), pick_key(), $urandom, quiet ? 0 : pick_gap(), '0);
         end
      end

      start = 1'b0;
      while (heap_answers.size() != 0) @(negedge clock);
      repeat (END_CYCLES) @(posedge clock);

      $display("ran %0d requests: %0d stored, %0d removed, %0d refused full, %0d found empty",
               requests_taken, stored_count, removed_count, full_count, empty_count);
      $display("heap peaked at %0d entries across %0d capacity writes, %0d mismatches",
               peak_fill, csr_writes, mismatches);
      if (mismatches == 0) begin
         $display("SUCCESS");
      end else begin
         $display("FAILURE");
      end
      $finish;
   end

   initial begin
      #4_000_000;
      $display("timeout with %0d results outstanding", heap_answers.size());
      $display("FAILURE");
      $finish;
   end

endmodule
